### design/fnt_pkg.sv
package fnt_pkg;

  localparam int unsigned FlowW  = 16;
  localparam int unsigned BaseW  = 24;
  localparam int unsigned QuietW = 3;
  localparam int unsigned CfgW   = 16;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 48;

  localparam logic [FlowW-1:0]  NoiseLow       = 16'd50;
  localparam logic [FlowW-1:0]  SignalLevel    = 16'd70;
  localparam logic [FlowW-1:0]  FirstFlowLimit = 16'd2000;
  localparam logic [QuietW-1:0] QuietStop      = 3'd4;
  localparam logic [FlowW-1:0]  PosMax         = 16'hFFFF;
  localparam logic [BaseW-1:0]  BaseMax        = 24'hFF_FFFF;

  localparam logic [FlowW-1:0] CutoffReset   = 16'hFFFF;
  localparam logic [FlowW-1:0] MinCleanReset = 16'd360;

  // (x + 50) / 100 as floor((x + 50) * RecipMul / 2^RecipShift), exact for every 16-bit x (x + 50 <= 65585)
  localparam int unsigned RoundedW   = FlowW + 1;
  localparam int unsigned RecipShift = 23;
  localparam logic [RoundedW-1:0] RecipMul  = 17'd83887;
  localparam logic [RoundedW-1:0] HalfBase  = 17'd50;
  localparam int unsigned ProdW  = 2 * RoundedW;
  localparam int unsigned QuotW  = ProdW - RecipShift;

  typedef enum logic {
    REG_FLOW_CUTOFF     = 1'b0,
    REG_MIN_CLEAN_FLOWS = 1'b1
  } cfg_reg_t;

endpackage

### design/flowgram_noise_trimmer.sv
// Channel   | Direction | Payload (lowest bit first)
// s_axis    | in        | tdata: flow_value[15:0], read_length[31:16]; tlast: last_flow
// m_axis    | out       | tdata: accepted[0], clean_flows[16:1], base_count[40:17],
//           |           |        trim_applied[41], zero[47:42]
// cfg       | in        | cfg_we, cfg_index (0 flow_cutoff, 1 min_clean_flows), cfg_data
//
// One item per cycle unless a last flow waits: an input register, then the per-read update and result register.
// A result passes the input register and then the result register after its last flow is accepted.
// Only a last flow waits while the result register is full and not taken; other items always advance.
// rst is synchronous: registers take their reset values, per-read state clears.
module flowgram_noise_trimmer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fnt_pkg::InDataW-1:0]   s_axis_tdata,   // flow_value, read_length
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [fnt_pkg::OutDataW-1:0]  m_axis_tdata,   // accepted, clean_flows,
                                                        // base_count, trim_applied
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [fnt_pkg::CfgW-1:0]      cfg_data
);
  import fnt_pkg::*;

  logic [FlowW-1:0] flow_cutoff;
  logic [FlowW-1:0] min_clean_flows;

  logic             in_valid;
  logic [FlowW-1:0] in_flow;
  logic [FlowW-1:0] in_len;
  logic             in_last;

  logic [FlowW-1:0]  pos;
  logic              noise_seen;
  logic [FlowW-1:0]  first_noise_position;
  logic [QuietW-1:0] quiet_run;
  logic [BaseW-1:0]  base_total;

  logic              out_valid;
  logic [OutDataW-1:0] out_data;

  logic advance;

  logic [FlowW-1:0]    pos_next;
  logic                noise_seen_next;
  logic [FlowW-1:0]    first_noise_position_next;
  logic [QuietW-1:0]   quiet_run_next;
  logic [BaseW-1:0]    base_total_next;
  logic                stop;
  logic                count_it;
  logic [RoundedW-1:0] rounded;
  logic [ProdW-1:0]    prod;
  logic [QuotW-1:0]    quot;
  logic [BaseW:0]      base_sum;
  logic [FlowW-1:0]    clean;
  logic                acc;
  logic [BaseW-1:0]    bases;
  logic                trim;

  assign advance       = in_valid && (!in_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_comb begin
    rounded  = {1'b0, in_flow} + HalfBase;
    prod     = {{RoundedW{1'b0}}, rounded} * {{RoundedW{1'b0}}, RecipMul};
    quot     = prod[ProdW-1:RecipShift];
    base_sum = {1'b0, base_total} + {{(BaseW + 1 - QuotW){1'b0}}, quot};

    stop           = 1'b0;
    quiet_run_next = quiet_run;
    if (in_flow > NoiseLow) begin
      if (in_flow < SignalLevel) begin
        stop = 1'b1;
      end else begin
        quiet_run_next = '0;
      end
    end else begin
      if (quiet_run < QuietStop) begin
        quiet_run_next = quiet_run + 1'b1;
      end
      if (quiet_run_next >= QuietStop) begin
        stop = 1'b1;
      end
    end

    count_it = (pos < flow_cutoff) && (in_flow > SignalLevel) &&
               !((pos == '0) && (in_flow > FirstFlowLimit));

    noise_seen_next           = noise_seen;
    first_noise_position_next = first_noise_position;
    base_total_next           = base_total;
    if (noise_seen) begin
      quiet_run_next = quiet_run;
    end else if (stop) begin
      noise_seen_next           = 1'b1;
      first_noise_position_next = pos;
    end else if (count_it) begin
      base_total_next = base_sum[BaseW] ? BaseMax : base_sum[BaseW-1:0];
    end

    pos_next = (pos < PosMax) ? pos + 1'b1 : pos;

    clean = noise_seen_next ? first_noise_position_next : pos_next;
    acc   = clean >= min_clean_flows;
    bases = acc ? base_total_next : '0;
    trim  = acc && (bases < {{(BaseW - FlowW){1'b0}}, in_len});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_cutoff     <= CutoffReset;
      min_clean_flows <= MinCleanReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLOW_CUTOFF:     flow_cutoff     <= cfg_data;
        REG_MIN_CLEAN_FLOWS: min_clean_flows <= cfg_data;
        default:             ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_flow <= s_axis_tdata[FlowW-1:0];
      in_len  <= s_axis_tdata[2*FlowW-1:FlowW];
      in_last <= s_axis_tlast;
    end
  end

  // per-read state; clear after the last flow
  always_ff @(posedge clk) begin
    if (rst) begin
      pos                  <= '0;
      noise_seen           <= 1'b0;
      first_noise_position <= '0;
      quiet_run            <= '0;
      base_total           <= '0;
    end else if (advance) begin
      if (in_last) begin
        pos                  <= '0;
        noise_seen           <= 1'b0;
        first_noise_position <= '0;
        quiet_run            <= '0;
        base_total           <= '0;
      end else begin
        pos                  <= pos_next;
        noise_seen           <= noise_seen_next;
        first_noise_position <= first_noise_position_next;
        quiet_run            <= quiet_run_next;
        base_total           <= base_total_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_data <= {{(OutDataW - 2 - FlowW - BaseW){1'b0}}, trim, bases, clean, acc};
    end
  end

endmodule
